### rtl/core/tgarle_pkg.sv
// Shared types and constants for the TGA RLE pixel decoder.
// Used by the register, front, queue, back and top modules and the bench; no dependencies.
package tgarle_pkg;

	localparam int MAX_SIDE = 8192;
	localparam int PIX_CNT_W = 27;
	localparam longint PIX_MAX = (longint'(1) << PIX_CNT_W) - 1;
	localparam longint SIDE_SQ = longint'(MAX_SIDE) * longint'(MAX_SIDE);
	// pixel count cap, saturated to the register width
	localparam logic [PIX_CNT_W-1:0] PIX_LIMIT =
		PIX_CNT_W'((SIDE_SQ > PIX_MAX) ? PIX_MAX : SIDE_SQ);

	localparam int CFG_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] HDR_LEN_MASK = 8'h7F;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic [1:0] {
		REG_RLE_MODE    = 2'd0,
		REG_BPP         = 2'd1,
		REG_PIXEL_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		FMT_GRAY   = 2'd0,
		FMT_RGB555 = 2'd1,
		FMT_BGR    = 2'd2,
		FMT_BGRA   = 2'd3
	} fmt_t;

	typedef struct packed {
		logic                 rle_mode;
		logic [2:0]           bytes_per_pixel;
		logic [PIX_CNT_W-1:0] pixel_count;
	} cfg_t;

	// one finished sample on its way to color conversion
	typedef struct packed {
		logic [23:0] sample;
		logic [7:0]  last_byte;
		fmt_t        fmt;
		logic [7:0]  repeat_cnt;
		logic        image_done;
		logic        overrun;
	} pix_cmd_t;

endpackage

### rtl/core/tgarle_if.sv
// Valid/ready stream interfaces for the byte input and the pixel output.
// Standalone; widths follow the fixed field widths of the decoder.
interface tgarle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_image;

	modport source(output valid, data_byte, start_of_image, input ready);
	modport sink(input valid, data_byte, start_of_image, output ready);
endinterface

interface tgarle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic [7:0] repeat_res;
	logic       image_done;
	logic       overrun;

	modport source(output valid, red, green, blue, alpha, repeat_res, image_done, overrun,
		input ready);
	modport sink(input valid, red, green, blue, alpha, repeat_res, image_done, overrun,
		output ready);
endinterface

### rtl/core/tgarle_regs.sv
// APB configuration registers: mode, bytes per pixel, pixel count.
// Depends on tgarle_pkg.
module tgarle_regs import tgarle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rle_mode        <= 1'b0;
			cfg_q.bytes_per_pixel <= 3'd4;
			cfg_q.pixel_count     <= PIX_CNT_W'(1);
		end else if (wr_en) begin
			case (idx)
				REG_RLE_MODE:    cfg_q.rle_mode        <= pwdata[0];
				REG_BPP:         cfg_q.bytes_per_pixel <= pwdata[2:0];
				REG_PIXEL_COUNT: cfg_q.pixel_count     <= pwdata[PIX_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_RLE_MODE:    prdata[0]              = cfg_q.rle_mode;
			REG_BPP:         prdata[2:0]            = cfg_q.bytes_per_pixel;
			REG_PIXEL_COUNT: prdata[PIX_CNT_W-1:0] = cfg_q.pixel_count;
			default:         prdata = '0;
		endcase
	end

endmodule

### rtl/core/tgarle_front.sv
// Front end: takes stream bytes, tracks packets, samples and pixel count,
// and issues one command per finished sample of the image. Depends on tgarle_pkg, tgarle_if.
module tgarle_front import tgarle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	tgarle_in_if.sink  byte_in,
	input  logic       q_ready,
	output logic       push,
	output pix_cmd_t   cmd
);

	logic                 expect_hdr_q, pkt_run_q;
	logic [7:0]           pkt_left_q;
	logic [1:0]           byte_idx_q;
	logic [23:0]          sample_q;
	logic [PIX_CNT_W-1:0] done_q;

	logic                 accept, sof;
	logic                 cur_expect, cur_run;
	logic [7:0]           cur_left;
	logic [1:0]           cur_idx;
	logic [23:0]          cur_sample, sample_ins;
	logic [PIX_CNT_W-1:0] cur_done, total, remaining;
	logic                 finished, take_hdr, sample_end, pkt_end, clip;
	logic [2:0]           bpp;
	fmt_t                 fmt;
	logic [7:0]           data, left_eff, cnt_pre, count;

	assign byte_in.ready = q_ready;
	assign accept        = byte_in.valid & q_ready;
	assign sof           = byte_in.start_of_image;
	assign data          = byte_in.data_byte;

	// start of image clears packet state before the byte is used
	assign cur_expect = sof | expect_hdr_q;
	assign cur_run    = sof ? 1'b0 : pkt_run_q;
	assign cur_left   = sof ? 8'd0 : pkt_left_q;
	assign cur_idx    = sof ? 2'd0 : byte_idx_q;
	assign cur_sample = sof ? 24'd0 : sample_q;
	assign cur_done   = sof ? '0 : done_q;

	always_comb begin
		case (cfg.bytes_per_pixel)
			3'd1:    begin bpp = 3'd1; fmt = FMT_GRAY;   end
			3'd2:    begin bpp = 3'd2; fmt = FMT_RGB555; end
			3'd3:    begin bpp = 3'd3; fmt = FMT_BGR;    end
			default: begin bpp = 3'd4; fmt = FMT_BGRA;   end
		endcase
	end

	assign total      = (cfg.pixel_count < PIX_LIMIT) ? cfg.pixel_count : PIX_LIMIT;
	assign finished   = cur_done >= total;
	assign remaining  = total - cur_done;
	assign take_hdr   = cfg.rle_mode & cur_expect;
	assign sample_end = ({1'b0, cur_idx} + 3'd1) >= bpp;
	// byte at index 3 shifts out of the 24-bit word
	assign sample_ins = cur_sample | (24'(data) << {cur_idx, 3'b000});

	assign left_eff = (cur_left == 8'd0) ? 8'd1 : cur_left;
	assign cnt_pre  = (cfg.rle_mode & cur_run) ? left_eff : 8'd1;
	assign clip     = PIX_CNT_W'(cnt_pre) > remaining;
	assign count    = clip ? remaining[7:0] : cnt_pre;
	assign pkt_end  = cur_run | (left_eff <= 8'd1);

	assign push           = accept & ~finished & ~take_hdr & sample_end;
	assign cmd.sample     = cur_sample;
	assign cmd.last_byte  = data;
	assign cmd.fmt        = fmt;
	assign cmd.repeat_cnt = count;
	assign cmd.image_done = PIX_CNT_W'(count) == remaining;
	assign cmd.overrun    = cfg.rle_mode & cmd.image_done & (left_eff > count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_hdr_q <= 1'b1;
			pkt_run_q    <= 1'b0;
			pkt_left_q   <= 8'd0;
			byte_idx_q   <= 2'd0;
			sample_q     <= 24'd0;
			done_q       <= '0;
		end else if (accept) begin
			expect_hdr_q <= cur_expect;
			pkt_run_q    <= cur_run;
			pkt_left_q   <= cur_left;
			byte_idx_q   <= cur_idx;
			sample_q     <= cur_sample;
			done_q       <= cur_done;
			if (!finished) begin
				if (take_hdr) begin
					pkt_run_q    <= data[7];
					pkt_left_q   <= (data & HDR_LEN_MASK) + 8'd1;
					expect_hdr_q <= 1'b0;
					byte_idx_q   <= 2'd0;
					sample_q     <= 24'd0;
				end else if (!sample_end) begin
					sample_q   <= sample_ins;
					byte_idx_q <= cur_idx + 2'd1;
				end else begin
					byte_idx_q <= 2'd0;
					sample_q   <= 24'd0;
					done_q     <= cur_done + PIX_CNT_W'(count);
					// raw mode leaves packet state untouched
					if (cfg.rle_mode) begin
						if (pkt_end) begin
							pkt_left_q   <= 8'd0;
							expect_hdr_q <= 1'b1;
						end else begin
							pkt_left_q <= left_eff - 8'd1;
						end
					end
				end
			end
		end
	end

endmodule

### rtl/core/tgarle_queue.sv
// Small register FIFO of pixel commands between front and back end.
// Depends on tgarle_pkg.
module tgarle_queue import tgarle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pix_cmd_t push_data,
	output logic     space,
	input  logic     pop,
	output logic     avail,
	output pix_cmd_t head
);

	pix_cmd_t          ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign space = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign avail = cnt_q != '0;
	assign head  = ent_q[rd_ptr_q];

	// depth is a power of two, pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_data;
	end

endmodule

### rtl/core/tgarle_back.sv
// Back end: converts a queued sample to RGBA and holds it in the output register.
// Depends on tgarle_pkg, tgarle_if.
module tgarle_back import tgarle_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          avail,
	input  pix_cmd_t      head,
	output logic          pop,
	tgarle_out_if.source  pixel_out
);

	logic       valid_q;
	logic [7:0] red_q, green_q, blue_q, alpha_q, repeat_q;
	logic       done_q, overrun_q;
	logic [7:0] r, g, b, a, b0, b1, b2, lb;

	assign b0 = head.sample[7:0];
	assign b1 = head.sample[15:8];
	assign b2 = head.sample[23:16];
	assign lb = head.last_byte;

	always_comb begin
		case (head.fmt)
			FMT_BGRA: begin
				r = b2; g = b1; b = b0; a = lb;
			end
			FMT_BGR: begin
				r = lb; g = b1; b = b0; a = ALPHA_OPAQUE;
			end
			FMT_RGB555: begin
				// little-endian word {lb, b0}: A1 R5 G5 B5
				b = {b0[4:0], 3'b000};
				g = {lb[1:0], b0[7:5], 3'b000};
				r = {lb[6:2], 3'b000};
				a = lb[7] ? ALPHA_OPAQUE : 8'd0;
			end
			default: begin
				r = lb; g = lb; b = lb; a = ALPHA_OPAQUE;
			end
		endcase
	end

	assign pop = avail & (~valid_q | pixel_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (~valid_q | pixel_out.ready) begin
			valid_q <= avail;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			red_q     <= r;
			green_q   <= g;
			blue_q    <= b;
			alpha_q   <= a;
			repeat_q  <= head.repeat_cnt;
			done_q    <= head.image_done;
			overrun_q <= head.overrun;
		end
	end

	assign pixel_out.valid      = valid_q;
	assign pixel_out.red        = red_q;
	assign pixel_out.green      = green_q;
	assign pixel_out.blue       = blue_q;
	assign pixel_out.alpha      = alpha_q;
	assign pixel_out.repeat_res = repeat_q;
	assign pixel_out.image_done = done_q;
	assign pixel_out.overrun    = overrun_q;

endmodule

### rtl/core/tga_rle_pixel_decoder_core.sv
// TGA pixel-data decoder top level: registers, front end, queue, back end.
// Depends on tgarle_pkg, tgarle_if and the tgarle_* modules.
//
// Usage: byte_in carries the pixel-data stream after the file header, one byte
// per request; start_of_image marks the first byte of a new image. pixel_out
// carries RGBA pixels with a repeat count, so a whole run leaves as one request.
// Packet header bytes and non-final sample bytes produce nothing.
// Software sets rle_mode (0x0), bytes_per_pixel (0x4) and pixel_count (0x8)
// over APB before the stream starts, while the block is idle.
// Throughput: one byte per cycle while the queue has space; the front end
// updates packet and pixel counters per byte with 27-bit subtracts and compares.
// A pixel's command enters a queue entry when its last byte is taken and then
// moves to the output register, which drives it on pixel_out.
// When pixel_out stalls, the two-entry command queue fills and byte_in.ready
// drops until the output register drains. Bytes past the end of the image are
// accepted and dropped.
// Reset (arst_n low) clears packet state, counters and the queue, and loads
// rle_mode 0, bytes_per_pixel 4, pixel_count 1.
module tga_rle_pixel_decoder_core import tgarle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	tgarle_in_if.sink             byte_in,
	tgarle_out_if.source          pixel_out
);

	cfg_t     cfg;
	pix_cmd_t cmd, head;
	logic     push, space, pop, avail;

	tgarle_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgarle_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.byte_in (byte_in),
		.q_ready (space),
		.push    (push),
		.cmd     (cmd)
	);

	tgarle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.space     (space),
		.pop       (pop),
		.avail     (avail),
		.head      (head)
	);

	tgarle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.head      (head),
		.pop       (pop),
		.pixel_out (pixel_out)
	);

endmodule

### rtl/core/tgarle_checker.sv
// Port-level checks on the decoder output, attached to the top level by bind.
// Depends on tga_rle_pixel_decoder_core and tgarle_if.
module tgarle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha,
	input logic [7:0] repeat_res,
	input logic       image_done,
	input logic       overrun
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({red, green, blue, alpha, repeat_res, image_done, overrun}))
		else $error("pixel request changed while stalled");

	a_repeat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> repeat_res != 8'd0 && repeat_res <= 8'd128)
		else $error("repeat count outside 1..128");

	// a clipped packet always ends the image
	a_overrun_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun |-> image_done)
		else $error("overrun without image_done");

endmodule

bind tga_rle_pixel_decoder_core tgarle_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (pixel_out.valid),
	.out_ready  (pixel_out.ready),
	.red        (pixel_out.red),
	.green      (pixel_out.green),
	.blue       (pixel_out.blue),
	.alpha      (pixel_out.alpha),
	.repeat_res (pixel_out.repeat_res),
	.image_done (pixel_out.image_done),
	.overrun    (pixel_out.overrun)
);

### sim/tb_tga_rle_pixel_decoder_core.sv
// Self-checking bench for tga_rle_pixel_decoder_core: random TGA byte streams in,
// RGBA pixel requests checked against an in-bench decoder model.
// Depends on tgarle_pkg, tgarle_if and the decoder RTL.
module tb_tga_rle_pixel_decoder_core;
	import tgarle_pkg::*;

	localparam int          STIM_BYTES  = 1300;
	localparam int          SETTLE_CYC  = 8;
	localparam int          STUCK_LIMIT = 2000;
	localparam longint      PIX_CAP     = longint'(MAX_SIDE) * longint'(MAX_SIDE);
	localparam logic [26:0] COUNT_ONES  = 27'h7FFFFFF;

	typedef struct packed {
		logic [7:0] data;
		logic       soi;
	} stream_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] reps;
		logic       done;
		logic       ovr;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	tgarle_in_if  byte_if();
	tgarle_out_if pix_if();

	tga_rle_pixel_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.byte_in  (byte_if),
		.pixel_out(pix_if)
	);

	// register mirror
	logic        cfg_rle   = 1'b0;
	logic [2:0]  cfg_bpp   = 3'd4;
	logic [26:0] cfg_count = 27'd1;

	// decoder model state
	logic        st_hdr    = 1'b1;
	logic        st_run    = 1'b0;
	logic [7:0]  st_left   = 8'd0;
	logic [1:0]  st_idx    = 2'd0;
	logic [23:0] st_sample = 24'd0;
	logic [26:0] px_done   = 27'd0;

	stream_item_t stream_q[$];
	pixel_t       want_pixels[$];

	bit in_fire, out_fire;
	bit in_calm, out_calm;
	int unsigned in_gap, out_wait;
	int fail_count, stim_bytes, settings, pix_checked, clipped_seen, stuck_cycles;

	// generator state
	int unsigned cut_left;
	bit          pend_soi;

	function automatic int unsigned eff_bpp(input logic [2:0] b);
		return (b >= 3'd1 && b <= 3'd4) ? int'(b) : 4;
	endfunction

	function automatic int unsigned draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one stream byte through the decoder; queues the pixel it completes, if any
	task automatic decode_byte(input logic [7:0] bt, input logic soi);
		longint      total, remaining;
		int unsigned eb, left, cnt;
		logic [15:0] w;
		pixel_t      px;
		if (soi) begin
			st_hdr    = 1'b1;
			st_run    = 1'b0;
			st_left   = 8'd0;
			st_idx    = 2'd0;
			st_sample = 24'd0;
			px_done   = 27'd0;
		end
		total = (longint'(cfg_count) < PIX_CAP) ? longint'(cfg_count) : PIX_CAP;
		if (longint'(px_done) >= total)
			return;
		remaining = total - longint'(px_done);
		if (cfg_rle && st_hdr) begin
			st_run    = bt[7];
			st_left   = 8'(bt[6:0]) + 8'd1;
			st_hdr    = 1'b0;
			st_idx    = 2'd0;
			st_sample = 24'd0;
			return;
		end
		eb = eff_bpp(cfg_bpp);
		if (int'(st_idx) + 1 < eb) begin
			st_sample = st_sample | (24'(bt) << (8 * int'(st_idx)));
			st_idx    = st_idx + 2'd1;
			return;
		end
		case (eb)
			4: begin
				px.red = st_sample[23:16]; px.green = st_sample[15:8];
				px.blue = st_sample[7:0];  px.alpha = bt;
			end
			3: begin
				px.red = bt; px.green = st_sample[15:8];
				px.blue = st_sample[7:0]; px.alpha = 8'd255;
			end
			2: begin
				w = {bt, st_sample[7:0]};
				px.blue  = {w[4:0], 3'b000};
				px.green = {w[9:5], 3'b000};
				px.red   = {w[14:10], 3'b000};
				px.alpha = w[15] ? 8'd255 : 8'd0;
			end
			default: begin
				px.red = bt; px.green = bt; px.blue = bt; px.alpha = 8'd255;
			end
		endcase
		st_idx    = 2'd0;
		st_sample = 24'd0;
		if (cfg_rle) begin
			left = (st_left != 0) ? int'(st_left) : 1;
			cnt  = st_run ? left : 1;
			if (longint'(cnt) > remaining)
				cnt = int'(remaining);
			px.ovr = (longint'(cnt) == remaining) && (left > cnt);
			if (st_run || left <= 1) begin
				st_left = 8'd0;
				st_hdr  = 1'b1;
			end else begin
				st_left = 8'(left - 1);
			end
		end else begin
			cnt    = 1;
			px.ovr = 1'b0;
		end
		px_done = 27'(px_done + cnt);
		px.reps = 8'(cnt);
		px.done = longint'(px_done) >= total;
		want_pixels.push_back(px);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic soi);
		stream_item_t it;
		it.data = b;
		it.soi  = soi;
		stream_q.push_back(it);
		stim_bytes++;
	endtask

	// generator byte: honors a truncation point, marks the first byte of an image,
	// and now and then throws in a stray start_of_image
	task automatic push_byte(input logic [7:0] b);
		if (cut_left == 0)
			return;
		cut_left--;
		queue_byte(b, pend_soi || ($urandom_range(0, 199) == 0));
		pend_soi = 1'b0;
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_RLE_MODE:    cfg_rle   = val[0];
			REG_BPP:         cfg_bpp   = val[2:0];
			REG_PIXEL_COUNT: cfg_count = val[26:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until the stream is drained and every expected pixel came out
	task automatic settle();
		while (stream_q.size() != 0 || byte_if.valid || want_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic build_image(input bit soi_first);
		int unsigned eb, target, left, len;
		bit          run;
		eb       = eff_bpp(cfg_bpp);
		pend_soi = soi_first;
		cut_left = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 30) : 32'h4000_0000;
		// keep the last phase close to the byte budget
		if (stim_bytes + int'(cut_left) > STIM_BYTES + 64)
			cut_left = $unsigned(STIM_BYTES + 64 - stim_bytes);
		if (cfg_count == 0)
			target = 0;
		else if (cfg_count > 300)
			target = $urandom_range(5, 150);
		else
			target = cfg_count;
		if (target == 0) begin
			repeat ($urandom_range(1, 3)) push_byte(rand_byte());
		end else if (!cfg_rle) begin
			if (target > 60)
				target = 60;
			repeat (target * eb) push_byte(rand_byte());
		end else begin
			left = target;
			while (left > 0 && cut_left > 0) begin
				run = $urandom_range(0, 1);
				case ($urandom_range(0, 9))
					0: len = 128;
					1: len = left;
					2: len = $urandom_range(41, 128);
					3, 4: len = $urandom_range(9, 40);
					default: len = $urandom_range(1, 8);
				endcase
				if (!run && len > left + 2)
					len = left + $urandom_range(0, 2);
				if (len > 128)
					len = 128;
				push_byte({run, 7'(len - 1)});
				if (run)
					repeat (eb) push_byte(rand_byte());
				else
					repeat (len * eb) push_byte(rand_byte());
				left = (len >= left) ? 0 : left - len;
			end
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) push_byte(rand_byte());
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin : byte_driver
		stream_item_t it;
		if (arst_n) begin
			if (!byte_if.valid || in_fire) begin
				if (in_gap > 0) begin
					in_gap--;
					byte_if.valid <= 1'b0;
				end else if (stream_q.size() != 0) begin
					it = stream_q.pop_front();
					byte_if.valid          <= 1'b1;
					byte_if.data_byte      <= it.data;
					byte_if.start_of_image <= it.soi;
					in_gap = draw_wait(in_calm);
				end else begin
					byte_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_wait > 0) begin
				out_wait--;
				pix_if.ready <= 1'b0;
			end else begin
				pix_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : pixel_monitor
		pixel_t want;
		in_fire  = arst_n && byte_if.valid && byte_if.ready;
		out_fire = arst_n && pix_if.valid && pix_if.ready;
		if (in_fire)
			decode_byte(byte_if.data_byte, byte_if.start_of_image);
		if (out_fire) begin
			if (want_pixels.size() == 0) begin
				$error("pixel request with no pixel expected");
				fail_count++;
			end else begin
				want = want_pixels.pop_front();
				check_field("red", want.red, pix_if.red);
				check_field("green", want.green, pix_if.green);
				check_field("blue", want.blue, pix_if.blue);
				check_field("alpha", want.alpha, pix_if.alpha);
				check_field("repeat_res", want.reps, pix_if.repeat_res);
				check_field("image_done", want.done, pix_if.image_done);
				check_field("overrun", want.ovr, pix_if.overrun);
				pix_checked++;
				if (want.ovr)
					clipped_seen++;
			end
			out_wait = draw_wait(out_calm);
		end
	end

	// no request moved for too long: the block is hung
	always @(posedge clk) begin
		if (in_fire || out_fire)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] val;
		int          n_img;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		byte_if.valid = 1'b0; byte_if.data_byte = 8'd0; byte_if.start_of_image = 1'b0;
		pix_if.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: raw BGRA, one pixel, then a byte past the end
		queue_byte(8'h00, 1'b1); queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0); queue_byte(8'h7F, 1'b0);
		queue_byte(8'h33, 1'b0);
		settle();

		// RLE 15-bit: full-length run, literal, then a run clipped at the end
		cfg_write(REG_RLE_MODE, 32'd1);
		cfg_write(REG_BPP, 32'd2);
		cfg_write(REG_PIXEL_COUNT, 32'd131);
		queue_byte(8'hFF, 1'b1); queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
		queue_byte(8'h01, 1'b0); queue_byte(8'h1F, 1'b0); queue_byte(8'h00, 1'b0);
		queue_byte(8'hE0, 1'b0); queue_byte(8'h83, 1'b0);
		queue_byte(8'h85, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h7C, 1'b0);
		settle();

		// gray literal that outlasts the image
		cfg_write(REG_BPP, 32'd1);
		cfg_write(REG_PIXEL_COUNT, 32'd2);
		queue_byte(8'h02, 1'b1); queue_byte(8'h10, 1'b0);
		queue_byte(8'h20, 1'b0); queue_byte(8'h30, 1'b0);
		settle();

		// empty image, then bpp 7 acting as BGRA
		cfg_write(REG_RLE_MODE, 32'd0);
		cfg_write(REG_BPP, 32'd7);
		cfg_write(REG_PIXEL_COUNT, 32'd0);
		queue_byte(8'hAA, 1'b1);
		settle();
		cfg_write(REG_PIXEL_COUNT, 32'd1);
		queue_byte(8'h01, 1'b1); queue_byte(8'h02, 1'b0);
		queue_byte(8'h03, 1'b0); queue_byte(8'h04, 1'b0);
		settle();
		settings = 5;

		while (stim_bytes < STIM_BYTES) begin
			in_calm  = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 6) begin
				val = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
				val[0] = $urandom_range(0, 1);
				cfg_write(REG_RLE_MODE, val);
			end
			if ($urandom_range(0, 9) < 6) begin
				val = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
				val[2:0] = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 4))
					: 3'($urandom_range(0, 7));
				cfg_write(REG_BPP, val);
			end
			if ($urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 19))
					0: val = 32'd0;
					1: val = 32'd1;
					2: val = {5'd0, COUNT_ONES};
					3: val = 32'(PIX_CAP);
					4: val = 32'(PIX_CAP) + $urandom_range(1, 1000);
					5, 6: val = $urandom_range(49, 300);
					default: val = $urandom_range(1, 48);
				endcase
				cfg_write(REG_PIXEL_COUNT, val);
			end
			settings++;
			// a phase may pick up mid-sample or mid-packet from the last one
			n_img = $urandom_range(1, 3);
			for (int k = 0; k < n_img; k++)
				build_image((k != 0) || ($urandom_range(0, 4) != 0));
			settle();
		end

		if (want_pixels.size() != 0) begin
			$error("%0d expected pixels never came out", want_pixels.size());
			fail_count++;
		end
		$display("Sent %0d stream bytes under %0d register settings.", stim_bytes, settings);
		$display("Checked %0d pixel requests, %0d of them clipped.", pix_checked, clipped_seen);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
